FILE: sv/kvcf_pkg.sv
// package: types, constants and codes shared by the keyed value coalescer framer
package kvcf_pkg;

  localparam int DEF_TABLE_DEPTH       = 128;
  localparam int DEF_MAX_FRAME_ENTRIES = 32;

  localparam int KEY_W     = 16;
  localparam int TYPE_W    = 8;
  localparam int VAL_W     = 32;
  localparam int LIMIT_W   = 16;
  localparam int CNT_W     = 6;
  localparam int LEN_W     = 9;
  localparam int ENTRY_W   = KEY_W + TYPE_W + VAL_W;
  localparam int S_DATA_W  = KEY_W + TYPE_W + VAL_W + LIMIT_W;
  localparam int S_USER_W  = 1;
  localparam int M_DATA_W  = 1 + CNT_W + LEN_W + KEY_W + TYPE_W + VAL_W;
  localparam int M_USER_W  = 2;
  localparam int HDR_BYTES = 2;

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ENTRY   = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESP_OK,
    ST_RESP_FULL,
    ST_EMPTY,
    ST_HDR,
    ST_RD,
    ST_ENTRY
  } state_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_PUB_OK,
    OUT_PUB_FULL,
    OUT_HDR,
    OUT_ENTRY,
    OUT_EMPTY
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     walk;
    logic     wr_hit;
    logic     wr_append;
    logic     commit_flush;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic miss_done;
    logic full;
    logic in_flush;
    logic in_empty;
    logic out_free;
    logic walk_done;
  } status_t;

endpackage

FILE: sv/kvcf_ctrl.sv
// controller: sequences search, append, response and frame emission
module kvcf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kvcf_pkg::status_t status,
  output kvcf_pkg::cmd_t    cmd
);
  import kvcf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!status.in_flush) begin
            state_next = ST_SEARCH;
          end else if (status.in_empty) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_HDR;
          end
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          state_next = ST_RESP_OK;
        end else if (status.miss_done) begin
          state_next = status.full ? ST_RESP_FULL : ST_RESP_OK;
        end
      end
      ST_RESP_OK, ST_RESP_FULL, ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (status.out_free) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (status.out_free) begin
          state_next = status.walk_done ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_sel  = OUT_NONE;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      ST_SEARCH: begin
        cmd.walk = 1'b1;
        if (status.hit) begin
          cmd.wr_hit = 1'b1;
        end else if (status.miss_done && !status.full) begin
          cmd.wr_append = 1'b1;
        end
      end
      ST_RESP_OK: begin
        if (status.out_free) cmd.out_sel = OUT_PUB_OK;
      end
      ST_RESP_FULL: begin
        if (status.out_free) cmd.out_sel = OUT_PUB_FULL;
      end
      ST_EMPTY: begin
        if (status.out_free) cmd.out_sel = OUT_EMPTY;
      end
      ST_HDR: begin
        if (status.out_free) cmd.out_sel = OUT_HDR;
      end
      ST_RD: begin
        cmd.walk = 1'b1;
      end
      ST_ENTRY: begin
        if (status.out_free) begin
          cmd.out_sel      = OUT_ENTRY;
          cmd.commit_flush = status.walk_done;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/kvcf_datapath.sv
// datapath: ring table memory, pointers, key compare and output register
module kvcf_datapath #(
  parameter int TABLE_DEPTH       = kvcf_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_FRAME_ENTRIES = kvcf_pkg::DEF_MAX_FRAME_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kvcf_pkg::S_DATA_W-1:0] in_data,
  input  logic [kvcf_pkg::S_USER_W-1:0] in_user,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kvcf_pkg::M_DATA_W-1:0] out_data,
  output logic [kvcf_pkg::M_USER_W-1:0] out_user,
  output logic                          out_last,
  input  kvcf_pkg::cmd_t                cmd,
  output kvcf_pkg::status_t             status
);
  import kvcf_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int SW   = $clog2(2 * TABLE_DEPTH);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [AW-1:0]     walk_ptr;
  logic [CW-1:0]     walk_cnt;
  logic [AW-1:0]     rd_ptr;
  logic              rd_vld;
  logic              flush_q;
  logic [KEY_W-1:0]  key_q;
  logic [TYPE_W-1:0] type_q;
  logic [VAL_W-1:0]  bits_q;
  logic [CNT_W-1:0]  n_q;

  logic [KEY_W-1:0]    in_key;
  logic [TYPE_W-1:0]   in_type;
  logic [VAL_W-1:0]    in_bits;
  logic [LIMIT_W-1:0]  in_limit;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    n_calc;
  logic [CW-1:0]       walk_lim;
  logic                rd_en;
  logic [AW-1:0]       tail;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [LEN_W-1:0]    len_calc;
  logic [M_DATA_W-1:0] out_data_next;
  logic [M_USER_W-1:0] out_user_next;
  logic                out_last_next;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] sum;
    sum = SW'(a) + SW'(b);
    if (sum >= SW'(TABLE_DEPTH)) begin
      sum = sum - SW'(TABLE_DEPTH);
    end
    return AW'(sum);
  endfunction

  assign in_key   = in_data[KEY_W-1:0];
  assign in_type  = in_data[KEY_W +: TYPE_W];
  assign in_bits  = in_data[KEY_W+TYPE_W +: VAL_W];
  assign in_limit = in_data[KEY_W+TYPE_W+VAL_W +: LIMIT_W];

  assign lim    = (in_limit > LIMIT_W'(MAX_FRAME_ENTRIES)) ? CNT_W'(MAX_FRAME_ENTRIES)
                                                           : CNT_W'(in_limit);
  assign n_calc = (CMPW'(count) < CMPW'(lim)) ? CNT_W'(count) : lim;

  assign walk_lim = flush_q ? CW'(n_q) : count;
  assign rd_en    = cmd.walk && (walk_cnt < walk_lim);
  assign tail     = wrap_add(head, count);
  assign wr_en    = cmd.wr_hit || cmd.wr_append;
  assign wr_addr  = cmd.wr_hit ? rd_ptr : tail;
  assign len_calc = LEN_W'(HDR_BYTES) + {n_q, 3'b000};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {bits_q, type_q, key_q};
    end
    if (rd_en) begin
      rd_data <= mem[walk_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cmd.wr_append) begin
        count <= count + CW'(1);
      end
      if (cmd.commit_flush) begin
        head  <= wrap_add(head, CW'(n_q));
        count <= count - CW'(n_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flush_q  <= in_user[0];
      key_q    <= in_key;
      type_q   <= in_type;
      bits_q   <= in_bits;
      n_q      <= n_calc;
      walk_ptr <= head;
      walk_cnt <= '0;
    end else if (rd_en) begin
      rd_ptr   <= walk_ptr;
      walk_ptr <= (walk_ptr == AW'(TABLE_DEPTH - 1)) ? '0 : walk_ptr + AW'(1);
      walk_cnt <= walk_cnt + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sel != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_data_next = '0;
    out_user_next = KIND_PUBLISH;
    out_last_next = 1'b1;
    unique case (cmd.out_sel)
      OUT_PUB_OK: begin
        out_data_next[0] = 1'b1;
      end
      OUT_HDR: begin
        out_user_next                   = KIND_HEADER;
        out_data_next[1 +: CNT_W]       = n_q;
        out_data_next[1+CNT_W +: LEN_W] = len_calc;
        out_last_next                   = 1'b0;
      end
      OUT_ENTRY: begin
        out_user_next                           = KIND_ENTRY;
        out_data_next[1+CNT_W+LEN_W +: ENTRY_W] = rd_data;
        out_last_next                           = (walk_cnt == walk_lim);
      end
      OUT_EMPTY: begin
        out_user_next = KIND_EMPTY;
      end
      default: begin
        out_user_next = KIND_PUBLISH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sel != OUT_NONE) begin
      out_data <= out_data_next;
      out_user <= out_user_next;
      out_last <= out_last_next;
    end
  end

  assign status.hit       = rd_vld && (rd_data[KEY_W-1:0] == key_q);
  assign status.miss_done = !rd_vld && (walk_cnt == count);
  assign status.full      = (count == CW'(TABLE_DEPTH));
  assign status.in_flush  = in_user[0];
  assign status.in_empty  = (count == '0) || (in_limit == '0);
  assign status.out_free  = !out_valid || out_ready;
  assign status.walk_done = (walk_cnt == walk_lim);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(TABLE_DEPTH) || CW > CMPW)
    else $error("pending count above table depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_append |-> (count != CW'(TABLE_DEPTH)))
    else $error("append into a full table");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_flush |-> (CMPW'(n_q) <= CMPW'(count)) && (n_q != '0))
    else $error("flush takes more entries than pending");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_sel != OUT_NONE) |-> (!out_valid || out_ready))
    else $error("output word overwritten while stalled");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!cmd.wr_append && !cmd.commit_flush) |=> $stable(count))
    else $error("pending count moved without append or flush");
`endif

endmodule

FILE: sv/keyed_value_coalescer_framer.sv
// top level: keyed value coalescer with frame output
//
// input stream: one word per request. tuser selects publish (0) or flush (1).
// a publish upserts a key into an ordered ring table; the key search reads the
// table one entry per cycle from the memory's registered read port and stops
// early on a key match; the answer word is loaded once the search ends, and the
// next request is taken after that word is loaded.
// a flush returns a header word and then one word per entry, oldest first,
// each entry read from the memory before its word is loaded;
// an empty table or a zero limit returns a single empty-flush word.
// tlast marks the final word caused by a request.
// one request is in work at a time; s_axis_tready is high only between them.
// the answer sits in an output register, so a new request is taken while the
// last word still waits; a stalled receiver holds the block in its current
// step with the word unchanged.
// reset empties the table at once (count and head cleared, no memory sweep).
module keyed_value_coalescer_framer #(
  parameter int TABLE_DEPTH       = kvcf_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_FRAME_ENTRIES = kvcf_pkg::DEF_MAX_FRAME_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_key, value_type, value_bits, max_entries
  input  logic [kvcf_pkg::S_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [kvcf_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // publish_ok, sent_count, frame_length, out_key, out_type, out_payload
  output logic [kvcf_pkg::M_DATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic [kvcf_pkg::M_USER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);
  import kvcf_pkg::*;

  cmd_t    cmd;
  status_t status;

  kvcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kvcf_datapath #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .MAX_FRAME_ENTRIES (MAX_FRAME_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
